/* hdl/ioc_pkg.sv */
// ----------------------------------------------------------------------------
// IMU offset correction package
// Shared widths, beat layouts and the saturating subtract used by the block.
// ----------------------------------------------------------------------------
package ioc_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int NUM_AXES    = 3;
   localparam int CAL_SAMPLES = 200;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] acc_x_raw;
      logic signed [SAMPLE_W-1:0] acc_y_raw;
      logic signed [SAMPLE_W-1:0] acc_z_raw;
      logic signed [SAMPLE_W-1:0] gyr_x_raw;
      logic signed [SAMPLE_W-1:0] gyr_y_raw;
      logic signed [SAMPLE_W-1:0] gyr_z_raw;
      logic                       start_gyro_cal;
      logic                       start_acc_cal;
   } req_beat_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] acc_x_out;
      logic signed [SAMPLE_W-1:0] acc_y_out;
      logic signed [SAMPLE_W-1:0] acc_z_out;
      logic signed [SAMPLE_W-1:0] gyr_x_out;
      logic signed [SAMPLE_W-1:0] gyr_y_out;
      logic signed [SAMPLE_W-1:0] gyr_z_out;
      logic                       gyro_cal_done;
      logic                       acc_cal_done;
      logic signed [SAMPLE_W-1:0] new_offset_x;
      logic signed [SAMPLE_W-1:0] new_offset_y;
      logic signed [SAMPLE_W-1:0] new_offset_z;
   } rsp_beat_type;

   // Status of one calibration engine for the beat in flight.
   typedef struct packed {
      logic zero;   // first pending beat: offsets and sums cleared
      logic done;   // last summed beat: offsets recomputed
   } cal_stat_type;

   // Sample minus offset, clamped to the signed 16-bit range.
   function automatic logic signed [SAMPLE_W-1:0] sat_sub(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [SAMPLE_W:0] diff;
      logic signed [SAMPLE_W-1:0] res;
      diff = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
         res = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         res = diff[SAMPLE_W-1:0];
      end
      return res;
   endfunction

endpackage

/* hdl/ioc_ifs.sv */
// ----------------------------------------------------------------------------
// IMU offset correction channels
// Valid/ready channels for the sample beats and the result beats.
// ----------------------------------------------------------------------------
interface ioc_req_if;
   logic                  valid;
   logic                  ready;
   ioc_pkg::req_beat_type beat;

   modport source (output valid, output beat, input ready);
   modport sink   (input valid, input beat, output ready);
endinterface

interface ioc_rsp_if;
   logic                  valid;
   logic                  ready;
   ioc_pkg::rsp_beat_type beat;

   modport source (output valid, output beat, input ready);
   modport sink   (input valid, input beat, output ready);
endinterface

/* hdl/ioc_div.sv */
// ----------------------------------------------------------------------------
// Constant divider
// Signed division by a fixed divisor, truncated toward zero, done as a
// multiply by a rounded-up reciprocal on the magnitude.
// ----------------------------------------------------------------------------
module ioc_div #(
   parameter int SumW    = 24,
   parameter int Divisor = ioc_pkg::CAL_SAMPLES
) (
   input  logic signed [SumW-1:0]              dividend,
   output logic signed [ioc_pkg::SAMPLE_W-1:0] quotient
);

   localparam int ShiftL = $clog2(Divisor);
   localparam int Shift  = SumW + ShiftL;
   localparam int RecipW = SumW + 2;
   localparam int ProdW  = SumW + RecipW;
   localparam int QW     = ioc_pkg::SAMPLE_W + 1;
   localparam logic [RecipW-1:0] Recip =
      RecipW'(((64'd1 << Shift) + 64'(Divisor) - 64'd1) / 64'(Divisor));

   logic [SumW-1:0]  mag;
   logic [ProdW-1:0] prod;
   logic [QW-1:0]    q_mag;
   logic [QW-1:0]    q_signed;

   // With the shift at SumW plus the divisor's bit count, the product gives
   // the exact floor for every magnitude below 2**SumW.
   always_comb begin
      mag      = dividend[SumW-1] ? SumW'(-dividend) : SumW'(dividend);
      prod     = ProdW'(mag) * ProdW'(Recip);
      q_mag    = prod[Shift +: QW];
      q_signed = dividend[SumW-1] ? (~q_mag + QW'(1)) : q_mag;
      quotient = q_signed[ioc_pkg::SAMPLE_W-1:0];
   end

endmodule

/* hdl/ioc_cal.sv */
// ----------------------------------------------------------------------------
// Calibration engine
// Holds one sensor's offsets, running sums, counter and pending flag, and
// recomputes the offsets as the mean of the summed samples.
// ----------------------------------------------------------------------------
module ioc_cal #(
   parameter int CalSamples = ioc_pkg::CAL_SAMPLES,
   parameter int SumAxes    = ioc_pkg::NUM_AXES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              start,
   input  logic                              enable,
   input  logic signed [ioc_pkg::SAMPLE_W-1:0] sample     [ioc_pkg::NUM_AXES],
   output logic signed [ioc_pkg::SAMPLE_W-1:0] offset     [ioc_pkg::NUM_AXES],
   output logic signed [ioc_pkg::SAMPLE_W-1:0] new_offset [ioc_pkg::NUM_AXES],
   output ioc_pkg::cal_stat_type             stat
);

   localparam int CntW = $clog2(CalSamples + 1);
   localparam int SumW = ioc_pkg::SAMPLE_W + CntW;
   localparam logic [CntW-1:0] LastCount = CntW'(CalSamples);

   logic                              pending_ff, pending_in;
   logic [CntW-1:0]                   count_ff, count_in;
   logic signed [ioc_pkg::SAMPLE_W-1:0] offset_ff [ioc_pkg::NUM_AXES];
   logic signed [ioc_pkg::SAMPLE_W-1:0] offset_in [ioc_pkg::NUM_AXES];
   logic signed [SumW-1:0]            sum_ff   [SumAxes];
   logic signed [SumW-1:0]            sum_in   [SumAxes];
   logic signed [SumW-1:0]            sum_next [SumAxes];
   logic signed [ioc_pkg::SAMPLE_W-1:0] div_q  [ioc_pkg::NUM_AXES];
   logic                              active, zeroing, finishing;

   for (genvar g = 0; g < ioc_pkg::NUM_AXES; g++) begin : g_axis
      if (g < SumAxes) begin : g_sum
         assign sum_next[g] = sum_ff[g] + SumW'(sample[g]);
         ioc_div #(.SumW(SumW), .Divisor(CalSamples)) u_div (
            .dividend (sum_next[g]),
            .quotient (div_q[g])
         );
      end else begin : g_fixed
         // Axes that are never summed get a zero offset on completion.
         assign div_q[g] = '0;
      end
   end

   always_comb begin
      active    = (pending_ff | start) & enable;
      zeroing   = active & (count_ff == '0);
      finishing = active & (count_ff != '0) & (count_ff >= LastCount);
      stat.zero = zeroing;
      stat.done = finishing;
   end

   always_comb begin
      pending_in = pending_ff;
      count_in   = count_ff;
      offset_in  = offset_ff;
      sum_in     = sum_ff;
      if (step) begin
         pending_in = (pending_ff | start) & ~finishing;
         if (zeroing) begin
            count_in = CntW'(1);
            for (int i = 0; i < ioc_pkg::NUM_AXES; i++) begin
               offset_in[i] = '0;
            end
            for (int i = 0; i < SumAxes; i++) begin
               sum_in[i] = '0;
            end
         end else if (active) begin
            sum_in = sum_next;
            if (finishing) begin
               count_in  = '0;
               offset_in = div_q;
            end else begin
               count_in = count_ff + CntW'(1);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < ioc_pkg::NUM_AXES; i++) begin
         offset[i]     = offset_ff[i];
         new_offset[i] = finishing ? div_q[i] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         count_ff   <= '0;
         for (int i = 0; i < ioc_pkg::NUM_AXES; i++) begin
            offset_ff[i] <= '0;
         end
         for (int i = 0; i < SumAxes; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
         offset_ff  <= offset_in;
         sum_ff     <= sum_in;
      end
   end

endmodule

/* hdl/imu_offset_correct_calibrate.sv */
// ----------------------------------------------------------------------------
// IMU offset correction with bias calibration
// Subtracts stored offsets from accelerometer and gyro samples with
// saturation, and recomputes the offsets by averaging on request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   req_bus   in         six raw samples, gyro and accel calibration start bits
//   rsp_bus   out        six corrected samples, done pulses, new offsets
//
// Every sample beat yields exactly one result beat. A beat is taken into the
// input register, corrected and run through both calibration engines in one
// pass of logic, and lands in the output register; the path is set by the
// offset subtract, the sum update and the reciprocal multiply of the mean.
// A new beat can be accepted every cycle while the output register is not stalled.
// When the output register is held by rsp_bus.ready low, the input register
// keeps its beat and req_bus.ready drops only once both registers are full.
// Synchronous reset clears the offsets, sums, counters and pending flags.
//
// The gyro engine runs first: on the beat where it clears or finishes, the
// accelerometer engine does not step, though a start request is still noted.
// Corrected outputs always use the offsets held before the beat's update.
module imu_offset_correct_calibrate #(
   parameter int CalSamples = ioc_pkg::CAL_SAMPLES
) (
   input  logic            clock,
   input  logic            reset,
   ioc_req_if.sink         req_bus,
   ioc_rsp_if.source       rsp_bus
);

   // Two-entry flow: input register feeding the output register.
   logic                  in_valid_ff, in_valid_in;
   ioc_pkg::req_beat_type in_beat_ff, in_beat_in;
   logic                  out_valid_ff, out_valid_in;
   ioc_pkg::rsp_beat_type out_beat_ff, out_beat_in;
   logic                  advance;
   logic                  step;
   logic                  take;

   logic signed [ioc_pkg::SAMPLE_W-1:0] acc_raw  [ioc_pkg::NUM_AXES];
   logic signed [ioc_pkg::SAMPLE_W-1:0] gyr_raw  [ioc_pkg::NUM_AXES];
   logic signed [ioc_pkg::SAMPLE_W-1:0] acc_corr [ioc_pkg::NUM_AXES];
   logic signed [ioc_pkg::SAMPLE_W-1:0] gyr_corr [ioc_pkg::NUM_AXES];
   logic signed [ioc_pkg::SAMPLE_W-1:0] acc_off  [ioc_pkg::NUM_AXES];
   logic signed [ioc_pkg::SAMPLE_W-1:0] gyr_off  [ioc_pkg::NUM_AXES];
   logic signed [ioc_pkg::SAMPLE_W-1:0] acc_new  [ioc_pkg::NUM_AXES];
   logic signed [ioc_pkg::SAMPLE_W-1:0] gyr_new  [ioc_pkg::NUM_AXES];
   ioc_pkg::cal_stat_type               gyro_stat;
   ioc_pkg::cal_stat_type               acc_stat;
   logic                                acc_enable;

   // The output register frees up when it is empty or being drained; the
   // input register can take a beat whenever it is empty or moving on.
   assign advance       = ~out_valid_ff | rsp_bus.ready;
   assign step          = in_valid_ff & advance;
   assign req_bus.ready = ~in_valid_ff | advance;
   assign take          = req_bus.valid & req_bus.ready;

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.beat  = out_beat_ff;

   always_comb begin
      acc_raw[0] = in_beat_ff.acc_x_raw;
      acc_raw[1] = in_beat_ff.acc_y_raw;
      acc_raw[2] = in_beat_ff.acc_z_raw;
      gyr_raw[0] = in_beat_ff.gyr_x_raw;
      gyr_raw[1] = in_beat_ff.gyr_y_raw;
      gyr_raw[2] = in_beat_ff.gyr_z_raw;
      for (int i = 0; i < ioc_pkg::NUM_AXES; i++) begin
         acc_corr[i] = ioc_pkg::sat_sub(acc_raw[i], acc_off[i]);
         gyr_corr[i] = ioc_pkg::sat_sub(gyr_raw[i], gyr_off[i]);
      end
   end

   ioc_cal #(.CalSamples(CalSamples), .SumAxes(ioc_pkg::NUM_AXES)) u_gyro_cal (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start      (in_beat_ff.start_gyro_cal),
      .enable     (1'b1),
      .sample     (gyr_corr),
      .offset     (gyr_off),
      .new_offset (gyr_new),
      .stat       (gyro_stat)
   );

   // The accelerometer Z axis is never summed; its offset comes back as zero.
   assign acc_enable = ~(gyro_stat.zero | gyro_stat.done);

   ioc_cal #(.CalSamples(CalSamples), .SumAxes(ioc_pkg::NUM_AXES - 1)) u_acc_cal (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start      (in_beat_ff.start_acc_cal),
      .enable     (acc_enable),
      .sample     (acc_corr),
      .offset     (acc_off),
      .new_offset (acc_new),
      .stat       (acc_stat)
   );

   always_comb begin
      in_valid_in = req_bus.ready ? req_bus.valid : in_valid_ff;
      in_beat_in  = take ? req_bus.beat : in_beat_ff;

      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_beat_in  = out_beat_ff;
      if (step) begin
         out_beat_in.acc_x_out     = acc_corr[0];
         out_beat_in.acc_y_out     = acc_corr[1];
         out_beat_in.acc_z_out     = acc_corr[2];
         out_beat_in.gyr_x_out     = gyr_corr[0];
         out_beat_in.gyr_y_out     = gyr_corr[1];
         out_beat_in.gyr_z_out     = gyr_corr[2];
         out_beat_in.gyro_cal_done = gyro_stat.done;
         out_beat_in.acc_cal_done  = acc_stat.done;
         // Each engine drives zeros unless it finished, and at most one can.
         out_beat_in.new_offset_x  = gyr_new[0] | acc_new[0];
         out_beat_in.new_offset_y  = gyr_new[1] | acc_new[1];
         out_beat_in.new_offset_z  = gyr_new[2] | acc_new[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff  <= in_beat_in;
      out_beat_ff <= out_beat_in;
   end

   // A gyro clearing or finishing beat must keep the accelerometer engine still.
   a_gyro_blocks_acc: assert property (@(posedge clock) disable iff (reset)
      (gyro_stat.zero || gyro_stat.done) |-> (!acc_stat.zero && !acc_stat.done))
      else $error("accelerometer calibration stepped on a gyro clear or finish beat");

   // A held beat in the input register is not dropped while the output stalls.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("input beat lost while output register stalled");

   // The two done pulses never share a result beat.
   a_one_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.beat.gyro_cal_done && rsp_bus.beat.acc_cal_done))
      else $error("both calibration done pulses on one beat");

   // Without a done pulse the new offset fields read as zero.
   a_idle_offsets: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.beat.gyro_cal_done && !rsp_bus.beat.acc_cal_done)
      |-> (rsp_bus.beat.new_offset_x == '0 && rsp_bus.beat.new_offset_y == '0
           && rsp_bus.beat.new_offset_z == '0))
      else $error("new offsets nonzero without a done pulse");

   // An accelerometer result always reports a zero Z offset.
   a_acc_z_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.beat.acc_cal_done) |-> (rsp_bus.beat.new_offset_z == '0))
      else $error("accelerometer Z offset not zero on completion");

endmodule
